// ===== design/rro_pkg.sv =====
`timescale 1ns / 1ps

package rro_pkg;

    localparam int CoordW      = 12;
    localparam int NStages     = 16;
    localparam int CordW       = 48;
    localparam int AngW        = 32;
    localparam int RotW        = 34;
    localparam int InvGainQ16  = 39797;
    localparam int InvGainQ30  = 652032875;

    localparam logic [2:0] RegCenterX = 3'd0;
    localparam logic [2:0] RegCenterY = 3'd1;
    localparam logic [2:0] RegInvDist = 3'd2;
    localparam logic [2:0] RegRayCnt  = 3'd3;
    localparam logic [2:0] RegRayGain = 3'd4;

    function automatic logic [AngW-1:0] atan_turn(input logic [4:0] i);
        logic [AngW-1:0] r;
        begin
            case (i)
                5'd0:    r = 32'h20000000;
                5'd1:    r = 32'h12E4051E;
                5'd2:    r = 32'h09FB385B;
                5'd3:    r = 32'h051111D4;
                5'd4:    r = 32'h028B0D43;
                5'd5:    r = 32'h0145D7E1;
                5'd6:    r = 32'h00A2F61E;
                5'd7:    r = 32'h00517C55;
                5'd8:    r = 32'h0028BE53;
                5'd9:    r = 32'h00145F2F;
                5'd10:   r = 32'h000A2F98;
                5'd11:   r = 32'h000517CC;
                5'd12:   r = 32'h00028BE6;
                5'd13:   r = 32'h000145F3;
                5'd14:   r = 32'h0000A2FA;
                5'd15:   r = 32'h0000517D;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } pix_t;

endpackage

// ===== design/radial_ray_overlay.sv =====
`timescale 1ns / 1ps
// channel  | dir | fields (low bit first)
// s_axis   | in  | tdata: pos_x[11:0] pos_y[23:12] red_in green_in blue_in alpha_in
// m_axis   | out | tdata: red_out green_out blue_out alpha_out
// cfg      | in  | cfg_we, cfg_index[2:0], cfg_data[23:0]
// one pixel per clock while m_axis does not stall; pipeline: offset stage, 16 vectoring stages, distance
// multiply, normalising and angle multiply, rotation load, 16 rotation stages,
// 3 for the intensity products, output register
// reset clears the valid bits and sets the configuration registers to their defaults
// a stall on m_axis freezes the whole pipeline; s_axis_tready follows it
module radial_ray_overlay import rro_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // pos_x, pos_y, red_in, green_in, blue_in, alpha_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // red_out, green_out, blue_out, alpha_out
);

    localparam int Lat = 2 * NStages + 8;

    logic [11:0] cx_reg, cy_reg;
    logic [23:0] inv_reg;
    logic [5:0]  rc_reg;
    logic [7:0]  gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg   <= '0;
            cy_reg   <= '0;
            inv_reg  <= '0;
            rc_reg   <= 6'd10;
            gain_reg <= 8'd100;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                RegCenterX: cx_reg   <= cfg_data[11:0];
                RegCenterY: cy_reg   <= cfg_data[11:0];
                RegInvDist: inv_reg  <= cfg_data;
                RegRayCnt:  rc_reg   <= cfg_data[5:0];
                RegRayGain: gain_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic [Lat-1:0] vld_reg;
    assign en            = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[Lat-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[Lat-2:0], s_axis_tvalid};
    end

    pix_t pix_reg [Lat-1];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pix_reg[0] <= {s_axis_tdata[31:24], s_axis_tdata[39:32],
                           s_axis_tdata[47:40], s_axis_tdata[55:48]};
            for (int k = 1; k < Lat - 1; k++)
                pix_reg[k] <= pix_reg[k-1];
        end
    end

    // stage 0: offsets, half-turn prefold
    logic signed [CordW-1:0] vx_reg [NStages+1];
    logic signed [CordW-1:0] vy_reg [NStages+1];
    logic [AngW-1:0]         va_reg [NStages+1];
    logic [NStages:0]        vz_reg;
    logic signed [12:0] dx, dy;
    assign dx = $signed({1'b0, s_axis_tdata[11:0]})  - $signed({1'b0, cx_reg});
    assign dy = $signed({1'b0, s_axis_tdata[23:12]}) - $signed({1'b0, cy_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vz_reg[0] <= (dx == 13'sd0) && (dy == 13'sd0);
            if (dx < 0)
            begin
                vx_reg[0] <= {{(CordW-29){~dx[12]}}, -dx, 16'd0};
                vy_reg[0] <= -{{(CordW-29){dy[12]}}, dy, 16'd0};
                va_reg[0] <= 32'h80000000;
            end
            else
            begin
                vx_reg[0] <= {{(CordW-29){dx[12]}}, dx, 16'd0};
                vy_reg[0] <= {{(CordW-29){dy[12]}}, dy, 16'd0};
                va_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < NStages; i++)
    begin : g_vec
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                vz_reg[i+1] <= vz_reg[i];
                if (!vy_reg[i][CordW-1])
                begin
                    vx_reg[i+1] <= vx_reg[i] + (vy_reg[i] >>> i);
                    vy_reg[i+1] <= vy_reg[i] - (vx_reg[i] >>> i);
                    va_reg[i+1] <= va_reg[i] + atan_turn(5'(i));
                end
                else
                begin
                    vx_reg[i+1] <= vx_reg[i] - (vy_reg[i] >>> i);
                    vy_reg[i+1] <= vy_reg[i] + (vx_reg[i] >>> i);
                    va_reg[i+1] <= va_reg[i] - atan_turn(5'(i));
                end
            end
        end
    end

    // distance and normalisation; x grows to at most ~2^29.3 so 30 bits hold it
    logic [29:0] mag;
    assign mag = vx_reg[NStages][CordW-1] ? 30'd0 : vx_reg[NStages][29:0];
    logic [29:0] dist_reg;
    logic [AngW-1:0] a1_reg, a2_reg;
    logic [16:0] rem_reg;
    logic [45:0] dm;
    logic [53:0] nm;
    assign dm = 46'(mag) * 46'(InvGainQ16);
    assign nm = 54'(dist_reg) * 54'(inv_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dist_reg <= dm[45:16];
            a1_reg   <= vz_reg[NStages] ? '0 : va_reg[NStages];
            rem_reg  <= (nm[53:24] >= 30'd65536) ? 17'd0 : 17'(30'd65536 - nm[53:24]);
            a2_reg   <= a1_reg * 32'(rc_reg);
        end
    end

    // rotation
    logic signed [RotW-1:0] rx_reg [NStages+1];
    logic signed [RotW-1:0] ry_reg [NStages+1];
    logic signed [AngW-1:0] rz_reg [NStages+1];
    logic [NStages:0]       flip_reg;
    logic [16:0]            rrem_reg [NStages+1];
    logic                   fl;
    logic [AngW-1:0]        am;
    assign fl = ~a2_reg[31] & a2_reg[30] | a2_reg[31] & ~a2_reg[30];
    assign am = fl ? a2_reg - 32'h80000000 : a2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg[0]   <= RotW'(InvGainQ30);
            ry_reg[0]   <= '0;
            rz_reg[0]   <= am;
            flip_reg[0] <= fl;
            rrem_reg[0] <= rem_reg;
        end
    end

    for (genvar i = 0; i < NStages; i++)
    begin : g_rot
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                flip_reg[i+1] <= flip_reg[i];
                rrem_reg[i+1] <= rrem_reg[i];
                if (!rz_reg[i][AngW-1])
                begin
                    rx_reg[i+1] <= rx_reg[i] - (ry_reg[i] >>> i);
                    ry_reg[i+1] <= ry_reg[i] + (rx_reg[i] >>> i);
                    rz_reg[i+1] <= rz_reg[i] - $signed(atan_turn(5'(i)));
                end
                else
                begin
                    rx_reg[i+1] <= rx_reg[i] + (ry_reg[i] >>> i);
                    ry_reg[i+1] <= ry_reg[i] - (rx_reg[i] >>> i);
                    rz_reg[i+1] <= rz_reg[i] + $signed(atan_turn(5'(i)));
                end
            end
        end
    end

    // sine, products, blend
    logic signed [RotW-1:0] yf;
    logic signed [RotW-16:0] sh;
    logic signed [15:0] sine;
    assign yf = flip_reg[NStages] ? -ry_reg[NStages] : ry_reg[NStages];
    assign sh = yf[RotW-1:15];
    assign sine = (sh > 32767) ? 16'sd32767 : (sh < -32768) ? -16'sd32768 : sh[15:0];

    logic signed [15:0] s_reg;
    logic [16:0] r_reg;
    logic        zero_reg, zero2_reg;
    logic [31:0] prod_reg;
    logic [7:0]  int_reg;
    logic [39:0] pg;
    assign pg = 40'(prod_reg) * 40'(gain_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg     <= sine;
            r_reg     <= rrem_reg[NStages];
            zero_reg  <= (inv_reg == '0);
            prod_reg  <= (s_reg > 0) ? 32'($unsigned(s_reg)) * 32'(r_reg) : 32'd0;
            zero2_reg <= zero_reg;
            int_reg   <= zero2_reg ? 8'd0 : ((pg[39:31] > 9'd255) ? 8'd255 : pg[38:31]);
        end
    end

    function automatic logic [7:0] sat(input logic [7:0] c, input logic [7:0] k);
        logic [8:0] s;
        begin
            s = {1'b0, c} + {1'b0, k};
            return s[8] ? 8'd255 : s[7:0];
        end
    endfunction

    logic [31:0] out_reg;
    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= {pix_reg[Lat-2].alpha, sat(pix_reg[Lat-2].blue, int_reg),
                        sat(pix_reg[Lat-2].green, int_reg), sat(pix_reg[Lat-2].red, int_reg)};
    end
    assign m_axis_tdata = out_reg;

endmodule

// ===== design/rro_checker.sv =====
`timescale 1ns / 1ps

module rro_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed under stall");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken during stall");

endmodule

bind radial_ray_overlay rro_checker u_chk (.*);
